// ===== hw/rtl/gbm_price_path_step_core_assert.svh =====
// Assertion macros for the price path step core checker.
`ifndef GBM_PRICE_PATH_STEP_CORE_ASSERT_SVH
`define GBM_PRICE_PATH_STEP_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define GBM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define GBM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gbm_pkg.sv =====
// Shared types and constants for the price path step core.
package gbm_pkg;

    localparam logic [28:0] LOG2E_Q28 = 29'd387270501;
    localparam logic signed [38:0] X_LIMIT = 39'sd17179869184;

    localparam logic [2:0] REG_START_PRICE = 3'd0;
    localparam logic [2:0] REG_DRIFT       = 3'd1;
    localparam logic [2:0] REG_VOLATILITY  = 3'd2;
    localparam logic [2:0] REG_STEP_YEARS  = 3'd3;
    localparam logic [2:0] REG_ROOT_STEP   = 3'd4;
    localparam logic [2:0] REG_STEP_TICKS  = 3'd5;
    localparam logic [2:0] REG_PATH_STEPS  = 3'd6;

    typedef struct packed {
        logic [31:0] start_price;
        logic [31:0] drift_rate;
        logic [31:0] volatility_rate;
        logic [31:0] step_years;
        logic [31:0] root_step_years;
        logic [31:0] step_ticks;
        logic [15:0] path_steps;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] normal_sample;
        logic               start;
        logic [47:0]        time_ticks;
        logic               last;
    } t_item;

    function automatic logic [28:0] pow2_coef(input logic [2:0] k);
        logic [28:0] c;
        case (k)
            3'd0: c = 29'd268435456;
            3'd1: c = 29'd186065279;
            3'd2: c = 29'd64485312;
            3'd3: c = 29'd14899271;
            3'd4: c = 29'd2581847;
            3'd5: c = 29'd357920;
            3'd6: c = 29'd41349;
            3'd7: c = 29'd4094;
            default: c = 29'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/gbm_front.sv =====
// Front end: accepts samples, tracks path position and timestamps.
module gbm_front import gbm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    input  logic [15:0] i_normal_sample,
    input  logic        i_q_full,
    output logic        o_in_stall,
    output logic        o_push,
    output t_item       o_item
);

    logic [15:0] r_step_index;
    logic [47:0] r_time;
    logic [15:0] n_step_index;
    logic [47:0] n_time;
    logic        n_start;
    logic        n_last;

    always_comb begin
        n_start = (r_step_index == 16'd0);
        n_time = n_start ? 48'd0 : (r_time + {16'd0, i_cfg.step_ticks});
        n_step_index = r_step_index + 16'd1;
        n_last = (n_step_index >= i_cfg.path_steps);
    end

    assign o_in_stall = i_q_full;
    assign o_push = i_in_valid && !i_q_full;
    assign o_item = '{normal_sample: i_normal_sample, start: n_start,
                      time_ticks: n_time, last: n_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_index <= 16'd0;
            r_time <= 48'd0;
        end else if (o_push) begin
            r_step_index <= n_last ? 16'd0 : n_step_index;
            r_time <= n_time;
        end
    end

endmodule

// ===== hw/rtl/gbm_fifo.sv =====
// Short queue of classified items between front and back.
module gbm_fifo import gbm_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_valid,
    output logic  o_full,
    output t_item o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full = (r_count == CW'(DEPTH));
    assign o_item = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/gbm_back.sv =====
// Back end: log increment, exp by 2^x polynomial, price update, output register.
module gbm_back import gbm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [47:0] o_timestamp_ticks,
    output logic [31:0] o_price,
    output logic        o_last_of_path
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_A, ST_T1, ST_X, ST_LOG, ST_SPLIT, ST_POLY, ST_MUL,
        ST_SHIFT, ST_DONE
    } t_state;

    t_state              r_st;
    t_item               r_item;
    logic [31:0]         r_cur_price;
    logic [31:0]         r_res;
    logic [34:0]         r_half;
    logic [31:0]         r_s;
    logic                r_a_neg;
    logic [35:0]         r_amag;
    logic [36:0]         r_t2m;
    logic [51:0]         r_phi;
    logic [35:0]         r_plo;
    logic                r_x_neg;
    logic [34:0]         r_ax;
    logic [35:0]         r_m;
    logic signed [8:0]   r_n;
    logic [27:0]         r_f;
    logic [28:0]         r_p;
    logic [2:0]          r_k;
    logic [60:0]         r_prod;
    logic                r_out_valid;
    logic [47:0]         r_out_ts;
    logic [31:0]         r_out_price;
    logic                r_out_last;

    logic [16:0]         n_zmag;
    logic [63:0]         n_vv;
    logic [63:0]         n_vs;
    logic signed [36:0]  n_a;
    logic [36:0]         n_aneg;
    logic [48:0]         n_t2;
    logic [51:0]         n_phi;
    logic [51:0]         n_plo;
    logic [52:0]         n_sum;
    logic signed [38:0]  n_t1s;
    logic signed [38:0]  n_t2s;
    logic signed [38:0]  n_x;
    logic signed [38:0]  n_xc;
    logic [38:0]         n_xabs;
    logic [63:0]         n_m64;
    logic [7:0]          n_nm;
    logic [27:0]         n_fm;
    logic signed [8:0]   n_n;
    logic [27:0]         n_f;
    logic [56:0]         n_pf;
    logic signed [9:0]   n_sh;
    logic signed [9:0]   n_up;
    logic [60:0]         n_q;
    logic [31:0]         n_res;
    logic                n_out_valid;

    always_comb begin
        n_zmag = r_item.normal_sample[15]
            ? (17'd0 - {r_item.normal_sample[15], r_item.normal_sample})
            : {1'b0, r_item.normal_sample};
        n_vv = {32'd0, i_cfg.volatility_rate} * {32'd0, i_cfg.volatility_rate};
        n_vs = {32'd0, i_cfg.volatility_rate} * {32'd0, i_cfg.root_step_years};
        n_a = $signed({{5{i_cfg.drift_rate[31]}}, i_cfg.drift_rate}) -
              $signed({2'b00, r_half});
        n_aneg = 37'd0 - n_a;
        n_t2 = {17'd0, r_s} * {32'd0, n_zmag};
        n_phi = {16'd0, r_amag} * {36'd0, i_cfg.step_years[31:16]};
        n_plo = {16'd0, r_amag} * {36'd0, i_cfg.step_years[15:0]};
        n_sum = {1'b0, r_phi} + {17'd0, r_plo};
        n_t1s = $signed({2'b00, n_sum[52:16]});
        n_t2s = $signed({2'b00, r_t2m});
        n_x = (r_a_neg ? -n_t1s : n_t1s) + (r_item.normal_sample[15] ? -n_t2s : n_t2s);
        n_xc = n_x;
        if (n_x > X_LIMIT) begin
            n_xc = X_LIMIT;
        end else if (n_x < -X_LIMIT) begin
            n_xc = -X_LIMIT;
        end
        n_xabs = n_xc[38] ? 39'(-n_xc) : n_xc;
        n_m64 = {29'd0, r_ax} * {35'd0, LOG2E_Q28};
        n_nm = r_m[35:28];
        n_fm = r_m[27:0];
        n_n = $signed({1'b0, n_nm});
        n_f = n_fm;
        if (r_x_neg) begin
            n_n = -$signed({1'b0, n_nm});
            if (n_fm != 28'd0) begin
                n_n = n_n - 9'sd1;
                n_f = 28'd0 - n_fm;
            end
        end
        n_pf = {28'd0, r_p} * {29'd0, r_f};
        n_sh = 10'sd28 - 10'(r_n);
        n_up = -n_sh;
        n_q = r_prod >> n_sh[5:0];
        n_res = 32'd0;
        if (n_sh >= 10'sd64) begin
            n_res = 32'd0;
        end else if (n_sh >= 10'sd0) begin
            n_res = (|n_q[60:32]) ? 32'hFFFF_FFFF : n_q[31:0];
        end else if (r_prod == 61'd0) begin
            n_res = 32'd0;
        end else if (n_up >= 10'sd32) begin
            n_res = 32'hFFFF_FFFF;
        end else if (r_prod > (61'h0_FFFF_FFFF >> n_up[4:0])) begin
            n_res = 32'hFFFF_FFFF;
        end else begin
            n_res = 32'(r_prod << n_up[4:0]);
        end
        n_out_valid = (r_out_valid && i_out_stall) || (r_st == ST_DONE);
    end

    assign o_q_pop = (r_st == ST_IDLE) && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_timestamp_ticks = r_out_ts;
    assign o_price = r_out_price;
    assign o_last_of_path = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cur_price <= 32'd0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_st)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_item;
                        if (i_q_item.start) begin
                            r_res <= i_cfg.start_price;
                            r_st <= ST_DONE;
                        end else begin
                            r_st <= ST_SQ;
                        end
                    end
                end
                ST_SQ: begin
                    r_half <= n_vv[63:29];
                    r_s <= n_vs[63:32];
                    r_st <= ST_A;
                end
                ST_A: begin
                    r_a_neg <= n_a[36];
                    r_amag <= n_a[36] ? n_aneg[35:0] : n_a[35:0];
                    r_t2m <= n_t2[48:12];
                    r_st <= ST_T1;
                end
                ST_T1: begin
                    r_phi <= n_phi;
                    r_plo <= n_plo[51:16];
                    r_st <= ST_X;
                end
                ST_X: begin
                    r_x_neg <= n_xc[38];
                    r_ax <= n_xabs[34:0];
                    r_st <= ST_LOG;
                end
                ST_LOG: begin
                    r_m <= n_m64[63:28];
                    r_st <= ST_SPLIT;
                end
                ST_SPLIT: begin
                    r_n <= n_n;
                    r_f <= n_f;
                    r_p <= pow2_coef(3'd7);
                    r_k <= 3'd6;
                    r_st <= ST_POLY;
                end
                ST_POLY: begin
                    r_p <= pow2_coef(r_k) + n_pf[56:28];
                    if (r_k == 3'd0) begin
                        r_st <= ST_MUL;
                    end else begin
                        r_k <= r_k - 3'd1;
                    end
                end
                ST_MUL: begin
                    r_prod <= {29'd0, r_cur_price} * {32'd0, r_p};
                    r_st <= ST_SHIFT;
                end
                ST_SHIFT: begin
                    r_res <= n_res;
                    r_st <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_cur_price <= r_res;
                        r_out_ts <= r_item.time_ticks;
                        r_out_price <= r_res;
                        r_out_last <= r_item.last;
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/gbm_price_path_step_core.sv =====
// Top level of the geometric Brownian motion price path step core.
// Input channel: i_in_valid / o_in_stall, one normal sample per beat (Q4.12).
// Output channel: o_out_valid / i_out_stall, one price point per input beat:
//   timestamp in ticks, price Q16.16 (saturated), last_of_path flag.
// Config: i_cfg_wr_en, i_cfg_index, i_cfg_data; write only while idle.
//   Indexes 0..6: start_price, drift, volatility, step_years,
//   root_step_years, step_ticks, path_steps. Index 7 is ignored.
// The front stage numbers each sample within its path and stamps its time,
// then queues it (QUEUE_DEPTH entries). The back stage runs one item at a time.
// A path start beat loads start_price directly; a later beat passes through
// the back sequencer: variance and drift terms, step multiply, exp2 range
// split, Horner steps on one multiplier, the price multiply and the final
// shift, before its result reaches the output register.
// Reset clears path position, timestamp, price, queue and output valid,
// and loads register defaults. While i_out_stall is high the result holds,
// the back stage waits after its next result, and the queue then fills
// before o_in_stall rises.
module gbm_price_path_step_core import gbm_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_normal_sample,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [47:0] o_timestamp_ticks,
    output logic [31:0] o_price,
    output logic        o_last_of_path
);

    t_cfg  r_cfg;
    logic  w_push;
    logic  w_pop;
    logic  w_q_valid;
    logic  w_q_full;
    t_item w_push_item;
    t_item w_q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_price <= 32'h0001_0000;
            r_cfg.drift_rate <= 32'd0;
            r_cfg.volatility_rate <= 32'd0;
            r_cfg.step_years <= 32'd0;
            r_cfg.root_step_years <= 32'd0;
            r_cfg.step_ticks <= 32'd1;
            r_cfg.path_steps <= 16'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_START_PRICE: r_cfg.start_price <= i_cfg_data;
                REG_DRIFT:       r_cfg.drift_rate <= i_cfg_data;
                REG_VOLATILITY:  r_cfg.volatility_rate <= i_cfg_data;
                REG_STEP_YEARS:  r_cfg.step_years <= i_cfg_data;
                REG_ROOT_STEP:   r_cfg.root_step_years <= i_cfg_data;
                REG_STEP_TICKS:  r_cfg.step_ticks <= i_cfg_data;
                REG_PATH_STEPS:  r_cfg.path_steps <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    gbm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .i_normal_sample (i_normal_sample),
        .i_q_full        (w_q_full),
        .o_in_stall      (o_in_stall),
        .o_push          (w_push),
        .o_item          (w_push_item)
    );

    gbm_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_item  (w_q_item)
    );

    gbm_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_q_valid         (w_q_valid),
        .i_q_item          (w_q_item),
        .o_q_pop           (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_timestamp_ticks (o_timestamp_ticks),
        .o_price           (o_price),
        .o_last_of_path    (o_last_of_path)
    );

endmodule

// ===== hw/rtl/gbm_checker.sv =====
// Port-level checker for the price path step core, bound to the top level.
`include "gbm_price_path_step_core_assert.svh"

module gbm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [47:0] o_timestamp_ticks,
    input logic [31:0] o_price,
    input logic        o_last_of_path
);

    `GBM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped under stall")
    `GBM_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_price) && $stable(o_timestamp_ticks) && $stable(o_last_of_path), "result changed under stall")
    `GBM_ASSERT_IMP(a_reset_clean, i_clk, i_rst_n, !$past(i_rst_n), !o_out_valid && !o_in_stall, "state left over from reset")
    `GBM_ASSERT_IMP(a_stall_rise, i_clk, i_rst_n, $rose(o_in_stall), $past(i_in_valid && !o_in_stall), "queue filled without an input beat")

endmodule

bind gbm_price_path_step_core gbm_checker u_gbm_checker (.*);
